// ----- src/aes128_block_cipher_unit_defines.svh -----
// Assertion macros for the AES-128 cipher unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef AES128_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES128_BLOCK_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication
`define AES_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes assertion failed");

// next-cycle implication
`define AES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes assertion failed");

`endif

// ----- src/aes_pkg.sv -----
// Shared types, constants and round functions for the AES-128 cipher unit.
// No dependencies.
package aes_pkg;

    localparam int ROUNDS      = 10;
    localparam int PIPE_STAGES = 2 * ROUNDS;
    localparam int LATENCY     = PIPE_STAGES + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] GF_REDUCE = 8'h1b;
    localparam logic [7:0] GF_TOPBIT = 8'h80;
    localparam logic [7:0] INV_AFF_C = 8'h05;

    typedef logic [3:0][31:0] state_t;   // four column words, row 0 in bits 31:24

    typedef struct packed {
        logic   dec;
        state_t st;
        state_t key;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (((a & GF_TOPBIT) != 8'h00) ? GF_REDUCE : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] aff_inv(input logic [7:0] y);
        return {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ INV_AFF_C;
    endfunction

    // inverse S-box through the forward table: inv(z) = aff_inv(sbox(aff_inv(z)))
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return aff_inv(sbox(aff_inv(x)));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic state_t key_expand(input state_t k, input logic [7:0] rc);
        state_t n;
        logic [31:0] t;
        t = sub_word({k[3][23:0], k[3][31:24]}) ^ {rc, 24'h0};
        n[0] = k[0] ^ t;
        n[1] = k[1] ^ n[0];
        n[2] = k[2] ^ n[1];
        n[3] = k[3] ^ n[2];
        return n;
    endfunction

    function automatic state_t key_unexpand(input state_t k, input logic [7:0] rc);
        state_t p;
        p[3] = k[3] ^ k[2];
        p[2] = k[2] ^ k[1];
        p[1] = k[1] ^ k[0];
        p[0] = k[0] ^ sub_word({p[3][23:0], p[3][31:24]}) ^ {rc, 24'h0};
        return p;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [7:0] m9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction
    function automatic logic [7:0] m11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction
    function automatic logic [7:0] m13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction
    function automatic logic [7:0] m14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3),
                m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3),
                m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3),
                m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3)};
    endfunction

    function automatic state_t enc_round(input state_t s, input state_t k, input logic last);
        state_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c][31-8*r -: 8] = sbox(s[(c + r) % 4][31-8*r -: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (!last) begin
                t[c] = mix_col(t[c]);
            end
            t[c] = t[c] ^ k[c];
        end
        return t;
    endfunction

    function automatic state_t dec_round(input state_t s, input state_t k, input logic last);
        state_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c][31-8*r -: 8] = inv_sbox(s[(c + 4 - r) % 4][31-8*r -: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            t[c] = t[c] ^ k[c];
            if (!last) begin
                t[c] = inv_mix_col(t[c]);
            end
        end
        return t;
    endfunction

    // byte n of {hi,lo} is cell [n/4][n%4]; column c holds bytes c, c+4, c+8, c+12
    function automatic state_t to_state(input logic [63:0] hi, input logic [63:0] lo);
        state_t s;
        logic [127:0] v;
        v = {hi, lo};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                s[c][31-8*r -: 8] = v[127-8*(4*r+c) -: 8];
            end
        end
        return s;
    endfunction

    function automatic logic [127:0] from_state(input state_t s);
        logic [127:0] v;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v[127-8*(4*r+c) -: 8] = s[c][31-8*r -: 8];
            end
        end
        return v;
    endfunction

endpackage

// ----- src/aes128_block_cipher_unit.sv -----
// AES-128 encrypt/decrypt unit, one block per cycle, fully pipelined.
// A block goes through the front register, the queue and the round pipeline.
// Throughput: one block every cycle; the 20-stage round pipeline never stalls.
// busy stays low in normal use since the queue drains every cycle.
// rst_n (async, active low) clears front valid, queue counters, stage valids.
`include "aes128_block_cipher_unit_defines.svh"

module aes128_block_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [63:0] data_hi,
    input  logic [63:0] data_lo,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    output logic        done,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);

    aes_pkg::q_stat_t q_stat;
    aes_pkg::item_t   f_item, q_item;
    logic             push, pop;

    aes_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .kind    (kind),
        .data_hi (data_hi),
        .data_lo (data_lo),
        .key_hi  (key_hi),
        .key_lo  (key_lo),
        .q_stat  (q_stat),
        .push    (push),
        .item    (f_item)
    );

    aes_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (f_item),
        .pop   (pop),
        .dout  (q_item),
        .stat  (q_stat)
    );

    aes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .item      (q_item),
        .pop       (pop),
        .done      (done),
        .result_hi (result_hi),
        .result_lo (result_lo)
    );

    `AES_ASSERT_IMPLY(a_done_latency, done, $past(start && !busy, aes_pkg::LATENCY))
    `AES_ASSERT_IMPLY(a_queue_drains, 1'b1, !q_stat.full)
    `AES_ASSERT_NEXT(a_push_lands, push, !q_stat.empty)

endmodule

// ----- src/aes_front.sv -----
// Front end: takes a command, reorders bytes into columns, applies the
// initial key for encryption. Depends on aes_pkg.
module aes_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           kind,
    input  logic [63:0]    data_hi,
    input  logic [63:0]    data_lo,
    input  logic [63:0]    key_hi,
    input  logic [63:0]    key_lo,
    input  aes_pkg::q_stat_t q_stat,
    output logic           push,
    output aes_pkg::item_t item
);

    logic           valid_reg, valid_next;
    aes_pkg::item_t item_reg, item_next;
    aes_pkg::state_t st_in, key_in;

    assign busy = valid_reg && q_stat.full;
    assign push = valid_reg && !q_stat.full;
    assign item = item_reg;

    always_comb
    begin
        st_in  = aes_pkg::to_state(data_hi, data_lo);
        key_in = aes_pkg::to_state(key_hi, key_lo);
        item_next.dec = kind;
        item_next.key = key_in;
        item_next.st  = kind ? st_in : (st_in ^ key_in);
        valid_next = valid_reg;
        if (start && !busy)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/aes_queue.sv -----
// Two-entry queue between front end and round pipeline.
// Depends on aes_pkg.
module aes_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aes_pkg::item_t   din,
    input  logic             pop,
    output aes_pkg::item_t   dout,
    output aes_pkg::q_stat_t stat
);

    localparam int PW = $clog2(aes_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(aes_pkg::QUEUE_DEPTH + 1);

    aes_pkg::item_t mem [aes_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CW'(aes_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign dout = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(aes_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(aes_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= din;
        end
    end

endmodule

// ----- src/aes_back.sv -----
// Round pipeline: ten forward key/encrypt stages, then ten inverse
// key/decrypt stages. Depends on aes_pkg.
module aes_back (
    input  logic             clk,
    input  logic             rst_n,
    input  aes_pkg::q_stat_t q_stat,
    input  aes_pkg::item_t   item,
    output logic             pop,
    output logic             done,
    output logic [63:0]      result_hi,
    output logic [63:0]      result_lo
);

    localparam int NS = aes_pkg::PIPE_STAGES;
    localparam int NR = aes_pkg::ROUNDS;

    aes_pkg::item_t pipe_reg  [NS];
    aes_pkg::item_t pipe_next [NS];
    logic [NS-1:0]  vld_reg, vld_next;
    logic [127:0]   res;

    // pipeline never stalls, so drain whenever something is queued
    assign pop = !q_stat.empty;
    assign vld_next = {vld_reg[NS-2:0], pop};

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_stage
            aes_pkg::item_t sin;
            if (g == 0)
            begin : g_first
                assign sin = item;
            end
            else
            begin : g_rest
                assign sin = pipe_reg[g-1];
            end

            if (g < NR)
            begin : g_fwd
                // round g+1: next round key; encrypt round or final key add
                always_comb
                begin
                    pipe_next[g].dec = sin.dec;
                    pipe_next[g].key = aes_pkg::key_expand(sin.key, aes_pkg::rcon(4'(g + 1)));
                    if (!sin.dec)
                    begin
                        pipe_next[g].st = aes_pkg::enc_round(sin.st, pipe_next[g].key,
                                                             (g == NR - 1));
                    end
                    else if (g == NR - 1)
                    begin
                        pipe_next[g].st = sin.st ^ pipe_next[g].key;
                    end
                    else
                    begin
                        pipe_next[g].st = sin.st;
                    end
                end
            end
            else
            begin : g_inv
                // steps decrypt key (round 2*NR-g) and state back one round
                always_comb
                begin
                    pipe_next[g] = sin;
                    if (sin.dec)
                    begin
                        pipe_next[g].key = aes_pkg::key_unexpand(sin.key,
                                                                 aes_pkg::rcon(4'(2 * NR - g)));
                        pipe_next[g].st  = aes_pkg::dec_round(sin.st, pipe_next[g].key,
                                                              (g == NS - 1));
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (vld_next[g])
                begin
                    pipe_reg[g] <= pipe_next[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign res       = aes_pkg::from_state(pipe_reg[NS-1].st);
    assign result_hi = res[127:64];
    assign result_lo = res[63:0];
    assign done      = vld_reg[NS-1];

endmodule

// ----- bench/aes128_block_cipher_checker.sv -----
// Checker for the AES-128 cipher unit: watches accepted beats, predicts results.
// No package dependency; the cipher itself is recomputed here.
module aes128_block_cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        kind,
    input  logic [63:0] data_hi,
    input  logic [63:0] data_lo,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    input  logic        done,
    input  logic [63:0] result_hi,
    input  logic [63:0] result_lo,
    output int          errors,
    output int          pending,
    output int          enc_seen,
    output int          dec_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   fwd_tab [256];
    logic [7:0]   rev_tab [256];
    logic [127:0] cipher_q [$];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input int c);
        logic [7:0] acc;
        acc = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (c[i])
                acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    // sbox built from GF inverse + affine map, independent of any table
    function automatic logic [7:0] calc_sbox(input logic [7:0] x);
        logic [7:0] inv, b;
        inv = 0;
        for (int y = 1; y < 256; y++)
        begin
            logic [7:0] p, a, m;
            p = 0; a = x; m = y[7:0];
            for (int i = 0; i < 8; i++)
            begin
                if (m[i])
                    p ^= a;
                a = dbl(a);
            end
            if (p == 8'h01)
                inv = y[7:0];
        end
        for (int i = 0; i < 8; i++)
            b[i] = inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
        return b ^ 8'h63;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            fwd_tab[i] = calc_sbox(i[7:0]);
            rev_tab[fwd_tab[i]] = i[7:0];
        end
    end

    function automatic logic [127:0] cipher_block(input logic decrypt, input logic [127:0] blk,
                                                  input logic [127:0] key);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] rk [11][16];
        logic [7:0] w [4];
        logic [7:0] col [4];
        logic [7:0] rc;
        logic [127:0] o;
        int fm [4];
        int im [4];
        fm = '{2, 3, 1, 1};
        im = '{14, 11, 13, 9};
        for (int n = 0; n < 16; n++)
        begin
            s[n] = blk[127-8*n -: 8];
            rk[0][n] = key[127-8*n -: 8];
        end
        rc = 8'h01;
        for (int r = 1; r <= 10; r++)
        begin
            for (int row = 0; row < 4; row++)
                w[row] = fwd_tab[rk[r-1][4*((row+1)%4)+3]];
            w[0] ^= rc;
            rc = dbl(rc);
            for (int row = 0; row < 4; row++)
                rk[r][4*row] = rk[r-1][4*row] ^ w[row];
            for (int c = 1; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    rk[r][4*row+c] = rk[r-1][4*row+c] ^ rk[r][4*row+c-1];
        end
        for (int n = 0; n < 16; n++)
            s[n] ^= rk[decrypt ? 10 : 0][n];
        for (int r = 1; r <= 10; r++)
        begin
            for (int row = 0; row < 4; row++)
                for (int c = 0; c < 4; c++)
                    t[4*row+c] = decrypt ? rev_tab[s[4*row+(c+4-row)%4]]
                                         : fwd_tab[s[4*row+(c+row)%4]];
            s = t;
            if (decrypt)
                for (int n = 0; n < 16; n++)
                    s[n] ^= rk[10-r][n];
            if (r < 10)
                for (int c = 0; c < 4; c++)
                begin
                    for (int row = 0; row < 4; row++)
                        col[row] = s[4*row+c];
                    for (int row = 0; row < 4; row++)
                    begin
                        logic [7:0] acc;
                        acc = 0;
                        for (int j = 0; j < 4; j++)
                            acc ^= gmul(col[j], decrypt ? im[(j+4-row)%4] : fm[(j+4-row)%4]);
                        s[4*row+c] = acc;
                    end
                end
            if (!decrypt)
                for (int n = 0; n < 16; n++)
                    s[n] ^= rk[r][n];
        end
        for (int n = 0; n < 16; n++)
            o[127-8*n -: 8] = s[n];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] exp_v;
        int           bad;
        if (!rst_n)
        begin
            errors   <= 0;
            pending  <= 0;
            enc_seen <= 0;
            dec_seen <= 0;
            cipher_q.delete();
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h_%h", $time, result_hi, result_lo);
                    bad = bad + 1;
                end
                else
                begin
                    exp_v = cipher_q.pop_front();
                    if (exp_v[127:64] !== result_hi)
                    begin
                        $display("%0t: result_hi expected %h actual %h",
                                 $time, exp_v[127:64], result_hi);
                        bad = bad + 1;
                    end
                    if (exp_v[63:0] !== result_lo)
                    begin
                        $display("%0t: result_lo expected %h actual %h",
                                 $time, exp_v[63:0], result_lo);
                        bad = bad + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                cipher_q.push_back(cipher_block(kind, {data_hi, data_lo}, {key_hi, key_lo}));
                if (kind)
                    dec_seen <= dec_seen + 1;
                else
                    enc_seen <= enc_seen + 1;
            end
            errors  <= errors + bad;
            pending <= cipher_q.size();
        end
    end
endmodule

// ----- bench/tb_aes128_block_cipher_unit.sv -----
// Top of the AES-128 cipher unit bench: clock, reset, stimulus and verdict.
// Depends on aes128_block_cipher_unit, aes_pkg and aes128_block_cipher_checker.
module tb_aes128_block_cipher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1230;
    localparam int WD_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [63:0] data_hi, data_lo, key_hi, key_lo;
    logic        done;
    logic [63:0] result_hi, result_lo;
    int          errors, pending, enc_seen, dec_seen;
    int          idle_cycles;

    aes128_block_cipher_unit dut (.*);

    aes128_block_cipher_checker chk (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // keeps start high between back-to-back beats; gap holds it low
    task automatic send_beat(input logic k, input logic [63:0] dh, input logic [63:0] dl,
                             input logic [63:0] kh, input logic [63:0] kl, input int gap);
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        kind    <= k;
        data_hi <= dh;
        data_lo <= dl;
        key_hi  <= kh;
        key_lo  <= kl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // watchdog: cycles with neither an accepted beat nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] pat [4];
        start = 0; kind = 0;
        data_hi = 0; data_lo = 0; key_hi = 0; key_lo = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pat = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0011_2233_4455_6677, 64'h8000_0000_0000_0001};
        // directed: corners of block and key in both modes
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 2; k++)
            begin
                send_beat(1'(k), pat[i], pat[3-i], pat[(i+1)%4], pat[i], 0);
                send_beat(1'(k), pat[3-i], pat[i], pat[i], pat[(i+2)%4], 1);
            end
        send_beat(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
                  64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 0);
        send_beat(1'b1, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
                  64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 0);

        for (int n = 0; n < N_RANDOM; n++)
            send_beat(1'($urandom_range(0, 1)), rnd64(), rnd64(), rnd64(), rnd64(),
                      (n % 200 < 40) ? 0 : pick_gap());
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (aes_pkg::LATENCY + 10) @(posedge clk);

        $display("tb: %0d encrypt and %0d decrypt blocks checked, corner and random keys",
                 enc_seen, dec_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
